@@ hw/rtl/jad_pkg.sv @@
// package for the joystick axis direction block
// holds widths, register and direction codes, lane stage type and helpers
// no dependencies
package jad_pkg;

  // converter resolution and derived widths
  localparam int ADC_BITS = 12;
  localparam int QB       = 7;               // quotient bits, enough to see 100
  localparam int NUM_W    = ADC_BITS + QB;   // holds full_scale * 100
  localparam int LANE_ST  = QB + 2;          // map stage, overflow stage, one per bit
  localparam int NST      = LANE_ST + 1;     // lane stages plus output register
  localparam int PCT_W    = 8;
  localparam int DIR_W    = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic [QB-1:0]           PCT_FULL_Q = QB'(100);
  localparam logic signed [PCT_W-1:0] PCT_FULL_P = PCT_W'(100);
  localparam logic signed [PCT_W-1:0] DIAG_P     = PCT_W'(40);

  // register reset values
  localparam logic [ADC_BITS-1:0] CENTRE_RST   = ADC_BITS'(2048);
  localparam logic [ADC_BITS-1:0] DEADZONE_RST = ADC_BITS'(20);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTRE_X  = 3'd0,
    REG_CENTRE_Y  = 3'd1,
    REG_DEADZONE  = 3'd2,
    REG_ADC_MAX   = 3'd3,
    REG_SWAP_AXES = 3'd4
  } cfg_idx_e;

  // direction codes
  typedef enum logic [DIR_W-1:0] {
    DIR_CENTRE    = 4'd0,
    DIR_UP        = 4'd1,
    DIR_DOWN      = 4'd2,
    DIR_LEFT      = 4'd3,
    DIR_RIGHT     = 4'd4,
    DIR_UPRIGHT   = 4'd5,
    DIR_UPLEFT    = 4'd6,
    DIR_DOWNRIGHT = 4'd7,
    DIR_DOWNLEFT  = 4'd8
  } dir_e;

  // one stage of an axis lane: partial remainder, divisor, quotient so far, flags
  typedef struct packed {
    logic [NUM_W-1:0]    rem;
    logic [ADC_BITS-1:0] dm;
    logic [QB-1:0]       q;
    logic                ovf;   // quotient at least 128
    logic                neg;   // result is negated
    logic                sub;   // below-centre branch, result is q - 100
    logic                zero;  // result forced to zero
  } lane_stage_t;

  // times one hundred by shifts and adds
  function automatic logic [NUM_W-1:0] mul100(input logic [ADC_BITS-1:0] x);
    logic [NUM_W-1:0] xw;
    xw = NUM_W'(x);
    return (xw << 6) + (xw << 5) + (xw << 2);
  endfunction

endpackage

@@ hw/rtl/jad_if.sv @@
// valid/ready channel interfaces for the joystick axis direction block
// depends on jad_pkg
interface jad_in_if;
  import jad_pkg::*;
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] raw_x;
  logic [ADC_BITS-1:0] raw_y;
  modport source (output valid, raw_x, raw_y, input ready);
  modport sink   (input valid, raw_x, raw_y, output ready);
endinterface

interface jad_out_if;
  import jad_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [PCT_W-1:0] pct_x;
  logic signed [PCT_W-1:0] pct_y;
  logic [DIR_W-1:0]        direction;
  modport source (output valid, pct_x, pct_y, direction, input ready);
  modport sink   (input valid, pct_x, pct_y, direction, output ready);
endinterface

@@ hw/rtl/jad_axis_lane.sv @@
// one axis lane: centre/deadzone mapping and a pipelined restoring divider
// depends on jad_pkg; stage enables come from the top level valid chain
module jad_axis_lane (
  input  logic                          clk_i,
  input  logic [jad_pkg::LANE_ST-1:0]   en_i,
  input  logic [jad_pkg::ADC_BITS-1:0]  raw_i,
  input  logic [jad_pkg::ADC_BITS-1:0]  centre_i,
  input  logic [jad_pkg::ADC_BITS-1:0]  deadzone_i,
  input  logic [jad_pkg::ADC_BITS-1:0]  adc_max_i,
  output jad_pkg::lane_stage_t          res_o
);
  import jad_pkg::*;

  lane_stage_t stage_d [LANE_ST];
  lane_stage_t stage_q [LANE_ST];

  logic                gt;
  logic [ADC_BITS-1:0] offs;
  logic                in_dz;
  logic [ADC_BITS:0]   span;

  // mapping stage: pick branch, build dividend and divisor magnitude
  // divider stages: overflow check, then one quotient bit per stage
  always_comb begin
    logic [NUM_W-1:0] trial;
    int               b;
    trial = '0;
    b     = 0;
    gt    = raw_i > centre_i;
    offs  = gt ? (raw_i - centre_i) : (centre_i - raw_i);
    in_dz = offs < deadzone_i;
    span  = {1'b0, adc_max_i} - {1'b0, centre_i};
    stage_d[0] = '0;
    if (gt) begin
      stage_d[0].rem  = mul100(raw_i - centre_i);
      stage_d[0].neg  = span[ADC_BITS];
      stage_d[0].dm   = span[ADC_BITS] ? ADC_BITS'(-span) : span[ADC_BITS-1:0];
      stage_d[0].zero = in_dz || (span == '0);
    end else begin
      stage_d[0].rem  = mul100(raw_i);
      stage_d[0].dm   = centre_i;
      stage_d[0].sub  = 1'b1;
      stage_d[0].zero = in_dz || (centre_i == '0);
    end
    for (int k = 1; k < LANE_ST; k++) begin
      stage_d[k] = stage_q[k-1];
      if (k == 1) begin
        stage_d[k].ovf = stage_q[k-1].rem >= {stage_q[k-1].dm, {QB{1'b0}}};
      end else begin
        b     = QB + 1 - k;
        trial = NUM_W'(stage_q[k-1].dm) << b;
        if (!stage_q[k-1].ovf && (stage_q[k-1].rem >= trial)) begin
          stage_d[k].rem = stage_q[k-1].rem - trial;
          stage_d[k].q   = stage_q[k-1].q | (QB'(1) << b);
        end
      end
    end
  end

  // stage registers, loaded when the stage moves
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < LANE_ST; k++) begin
      if (en_i[k]) begin
        stage_q[k] <= stage_d[k];
      end
    end
  end

  assign res_o = stage_q[LANE_ST-1];

endmodule

@@ hw/rtl/jad_dir_merge.sv @@
// merge stage: turns both lane quotients into percentages and a direction
// depends on jad_pkg; registers the result beat
module jad_dir_merge (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  jad_pkg::lane_stage_t           lane_x_i,
  input  jad_pkg::lane_stage_t           lane_y_i,
  output logic signed [jad_pkg::PCT_W-1:0] pct_x_o,
  output logic signed [jad_pkg::PCT_W-1:0] pct_y_o,
  output jad_pkg::dir_e                  dir_o
);
  import jad_pkg::*;

  // saturate quotient to 100 and apply branch sign / offset
  function automatic logic signed [PCT_W-1:0] finish(input lane_stage_t s);
    logic [QB-1:0]           qs;
    logic [QB-1:0]           sat;
    logic signed [PCT_W-1:0] p;
    qs  = s.ovf ? '1 : s.q;
    sat = (qs > PCT_FULL_Q) ? PCT_FULL_Q : qs;
    p   = PCT_W'(sat);
    if (s.zero) begin
      return '0;
    end else if (s.sub) begin
      return p - PCT_FULL_P;
    end else if (s.neg) begin
      return -p;
    end
    return p;
  endfunction

  logic signed [PCT_W-1:0] px, py, ax, ay;
  dir_e                    dir;

  // direction pick: centre, diagonals past the threshold, then larger axis
  always_comb begin
    px = finish(lane_x_i);
    py = finish(lane_y_i);
    ax = (px < 0) ? -px : px;
    ay = (py < 0) ? -py : py;
    if (px == '0 && py == '0) begin
      dir = DIR_CENTRE;
    end else if (py > DIAG_P && px > DIAG_P) begin
      dir = DIR_UPRIGHT;
    end else if (py > DIAG_P && px < -DIAG_P) begin
      dir = DIR_UPLEFT;
    end else if (py < -DIAG_P && px > DIAG_P) begin
      dir = DIR_DOWNRIGHT;
    end else if (py < -DIAG_P && px < -DIAG_P) begin
      dir = DIR_DOWNLEFT;
    end else if (ay > ax) begin
      dir = (py > 0) ? DIR_UP : DIR_DOWN;
    end else begin
      dir = (px > 0) ? DIR_RIGHT : DIR_LEFT;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pct_x_o <= px;
      pct_y_o <= py;
      dir_o   <= dir;
    end
  end

endmodule

@@ hw/rtl/joystick_axis_direction.sv @@
// top level of the joystick axis direction block
// depends on jad_pkg, jad_if, jad_axis_lane and jad_dir_merge
//
// Usage:
//   in_i carries one beat per pair of raw converter readings (raw_x, raw_y).
//   out_o carries one beat per input beat: pct_x, pct_y (-100..100) and a
//   direction code (centre, four straight, four diagonal).
//   The configuration port writes centre_x, centre_y, deadzone, adc_max and
//   swap_axes by index on cfg_we_i; change it only while the block is empty.
// Timing:
//   one beat per cycle sustained while out_o is ready. Each axis lane has one
//   mapping stage, one overflow stage and seven restoring divider stages,
//   followed by the merge register.
// Reset:
//   empties the pipeline and loads the register defaults (centres at mid
//   scale, deadzone 20, adc_max at full scale, no swap).
// Stall:
//   when out_o is held off, stages fill up behind the output register; in_i
//   keeps accepting while any stage is empty and holds ready low once full.
module joystick_axis_direction (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  jad_in_if.sink                           in_i,
  jad_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [jad_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [jad_pkg::ADC_BITS-1:0]     cfg_data_i
);
  import jad_pkg::*;

  logic [ADC_BITS-1:0] centre_x_q, centre_y_q, deadzone_q, adc_max_q;
  logic                swap_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_x_q <= CENTRE_RST;
      centre_y_q <= CENTRE_RST;
      deadzone_q <= DEADZONE_RST;
      adc_max_q  <= '1;
      swap_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_CENTRE_X:  centre_x_q <= cfg_data_i;
        REG_CENTRE_Y:  centre_y_q <= cfg_data_i;
        REG_DEADZONE:  deadzone_q <= cfg_data_i;
        REG_ADC_MAX:   adc_max_q  <= cfg_data_i;
        REG_SWAP_AXES: swap_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // valid chain: a stage moves when empty or when the one after it moves
  logic [NST-1:0] v_q, v_d, move;

  always_comb begin
    move[NST-1] = !v_q[NST-1] || out_o.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      move[k] = !v_q[k] || move[k+1];
    end
    v_d[0] = move[0] ? in_i.valid : v_q[0];
    for (int k = 1; k < NST; k++) begin
      v_d[k] = move[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_i.ready = move[0];

  // optional exchange of the readings
  logic [ADC_BITS-1:0] rx, ry;
  assign rx = swap_q ? in_i.raw_y : in_i.raw_x;
  assign ry = swap_q ? in_i.raw_x : in_i.raw_y;

  // one lane per axis
  lane_stage_t res_x, res_y;

  jad_axis_lane u_lane_x (
    .clk_i      (clk_i),
    .en_i       (move[LANE_ST-1:0]),
    .raw_i      (rx),
    .centre_i   (centre_x_q),
    .deadzone_i (deadzone_q),
    .adc_max_i  (adc_max_q),
    .res_o      (res_x)
  );

  jad_axis_lane u_lane_y (
    .clk_i      (clk_i),
    .en_i       (move[LANE_ST-1:0]),
    .raw_i      (ry),
    .centre_i   (centre_y_q),
    .deadzone_i (deadzone_q),
    .adc_max_i  (adc_max_q),
    .res_o      (res_y)
  );

  // merge and output register
  logic signed [PCT_W-1:0] pct_x, pct_y;
  dir_e                    dir;

  jad_dir_merge u_merge (
    .clk_i    (clk_i),
    .en_i     (move[NST-1]),
    .lane_x_i (res_x),
    .lane_y_i (res_y),
    .pct_x_o  (pct_x),
    .pct_y_o  (pct_y),
    .dir_o    (dir)
  );

  assign out_o.valid     = v_q[NST-1];
  assign out_o.pct_x     = pct_x;
  assign out_o.pct_y     = pct_y;
  assign out_o.direction = dir;

  // an empty output register lets the whole chain move
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[NST-1] |-> in_i.ready)
    else $error("input not ready while output register is empty");

  // centre exactly when both axes read zero
  a_centre_iff_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.pct_x == '0 && out_o.pct_y == '0) ==
                     (out_o.direction == DIR_CENTRE)))
    else $error("direction centre does not match zero percentages");

  // percentages stay within full scale
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.pct_x <= PCT_FULL_P && out_o.pct_x >= -PCT_FULL_P &&
                     out_o.pct_y <= PCT_FULL_P && out_o.pct_y >= -PCT_FULL_P))
    else $error("percentage out of range");

endmodule
